### design/uyvy2rgb_pkg.sv
// Package for the UYVY pair to RGB converter.
// Holds coefficients, widths, stage structs and the output clamp function.
// No dependencies.
package uyvy2rgb_pkg;

    localparam int unsigned YW   = 8;
    localparam int unsigned DW   = 9;
    localparam int unsigned CW   = 18;
    localparam int unsigned PW   = DW + CW;
    localparam int unsigned AW   = 28;
    localparam int unsigned OW   = 16;
    localparam int unsigned FRAC = 17;

    localparam logic signed [CW-1:0] COEF_R_V = 18'sd91881;
    localparam logic signed [CW-1:0] COEF_G_U = 18'sd22554;
    localparam logic signed [CW-1:0] COEF_G_V = 18'sd46802;
    localparam logic signed [CW-1:0] COEF_B_U = 18'sd116130;

    localparam logic [OW-1:0] FULL_SCALE = 16'd65280;
    localparam logic [AW-1:0] ROUND_HALF = 28'd256;
    localparam logic [9:0]    CHROMA_MID = 10'd255;

    typedef struct packed {
        logic                 valid;
        logic [YW-1:0]        luma_first;
        logic [YW-1:0]        luma_second;
        logic signed [PW-1:0] prod_r_v;
        logic signed [PW-1:0] prod_g_u;
        logic signed [PW-1:0] prod_g_v;
        logic signed [PW-1:0] prod_b_u;
    } t_prod_stage;

    typedef struct packed {
        logic                 valid;
        logic signed [AW-1:0] red_first;
        logic signed [AW-1:0] green_first;
        logic signed [AW-1:0] blue_first;
        logic signed [AW-1:0] red_second;
        logic signed [AW-1:0] green_second;
        logic signed [AW-1:0] blue_second;
    } t_acc_stage;

    typedef struct packed {
        logic          valid;
        logic [OW-1:0] red_first;
        logic [OW-1:0] green_first;
        logic [OW-1:0] blue_first;
        logic [OW-1:0] red_second;
        logic [OW-1:0] green_second;
        logic [OW-1:0] blue_second;
    } t_rgb_stage;

    // drop 9 fraction bits with round half up, then clamp to 0..FULL_SCALE
    function automatic logic [OW-1:0] clamp_chan(input logic signed [AW-1:0] acc);
        logic [AW-1:0] sum;
        logic [AW-10:0] v;
        sum = $unsigned(acc) + ROUND_HALF;
        v   = sum[AW-1:9];
        if (acc <= 0) begin
            return '0;
        end else if (v > (AW-9)'(FULL_SCALE)) begin
            return FULL_SCALE;
        end else begin
            return v[OW-1:0];
        end
    endfunction

endpackage

### design/uyvy2rgb_mul.sv
// Chroma offset and coefficient product stages (two register stages).
// Depends on uyvy2rgb_pkg.
module uyvy2rgb_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [7:0]                         i_cb_sample,
    input  logic [7:0]                         i_luma_first,
    input  logic [7:0]                         i_cr_sample,
    input  logic [7:0]                         i_luma_second,
    output uyvy2rgb_pkg::t_prod_stage          o_prod
);

    logic                                  r_v1;
    logic signed [uyvy2rgb_pkg::DW-1:0]    r_du;
    logic signed [uyvy2rgb_pkg::DW-1:0]    r_dv;
    logic [uyvy2rgb_pkg::YW-1:0]           r_y1;
    logic [uyvy2rgb_pkg::YW-1:0]           r_y2;
    logic [uyvy2rgb_pkg::DW-1:0]           n_du;
    logic [uyvy2rgb_pkg::DW-1:0]           n_dv;
    uyvy2rgb_pkg::t_prod_stage             r_prod;

    // offsets in half units: 2*C - 255
    assign n_du = {i_cb_sample, 1'b0} - uyvy2rgb_pkg::CHROMA_MID[uyvy2rgb_pkg::DW-1:0];
    assign n_dv = {i_cr_sample, 1'b0} - uyvy2rgb_pkg::CHROMA_MID[uyvy2rgb_pkg::DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_prod.valid <= 1'b0;
        end else begin
            r_v1         <= i_valid;
            r_prod.valid <= r_v1;
        end
        r_du <= $signed(n_du);
        r_dv <= $signed(n_dv);
        r_y1 <= i_luma_first;
        r_y2 <= i_luma_second;
        r_prod.luma_first  <= r_y1;
        r_prod.luma_second <= r_y2;
        r_prod.prod_r_v <= uyvy2rgb_pkg::PW'(r_dv) * uyvy2rgb_pkg::PW'(uyvy2rgb_pkg::COEF_R_V);
        r_prod.prod_g_u <= uyvy2rgb_pkg::PW'(r_du) * uyvy2rgb_pkg::PW'(uyvy2rgb_pkg::COEF_G_U);
        r_prod.prod_g_v <= uyvy2rgb_pkg::PW'(r_dv) * uyvy2rgb_pkg::PW'(uyvy2rgb_pkg::COEF_G_V);
        r_prod.prod_b_u <= uyvy2rgb_pkg::PW'(r_du) * uyvy2rgb_pkg::PW'(uyvy2rgb_pkg::COEF_B_U);
    end

    assign o_prod = r_prod;

endmodule

### design/uyvy2rgb_acc.sv
// Accumulate stage: luma base plus chroma products for both pixels.
// Depends on uyvy2rgb_pkg.
module uyvy2rgb_acc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  uyvy2rgb_pkg::t_prod_stage  i_prod,
    output uyvy2rgb_pkg::t_acc_stage   o_acc
);

    logic signed [uyvy2rgb_pkg::AW-1:0] n_base1;
    logic signed [uyvy2rgb_pkg::AW-1:0] n_base2;
    logic signed [uyvy2rgb_pkg::AW-1:0] n_rv;
    logic signed [uyvy2rgb_pkg::AW-1:0] n_gu;
    logic signed [uyvy2rgb_pkg::AW-1:0] n_gv;
    logic signed [uyvy2rgb_pkg::AW-1:0] n_bu;
    uyvy2rgb_pkg::t_acc_stage           r_acc;

    assign n_base1 = $signed({3'b000, i_prod.luma_first,
                              {uyvy2rgb_pkg::FRAC{1'b0}}});
    assign n_base2 = $signed({3'b000, i_prod.luma_second,
                              {uyvy2rgb_pkg::FRAC{1'b0}}});
    assign n_rv = uyvy2rgb_pkg::AW'(i_prod.prod_r_v);
    assign n_gu = uyvy2rgb_pkg::AW'(i_prod.prod_g_u);
    assign n_gv = uyvy2rgb_pkg::AW'(i_prod.prod_g_v);
    assign n_bu = uyvy2rgb_pkg::AW'(i_prod.prod_b_u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc.valid <= 1'b0;
        end else begin
            r_acc.valid <= i_prod.valid;
        end
        r_acc.red_first    <= n_base1 + n_rv;
        r_acc.green_first  <= n_base1 - n_gu - n_gv;
        r_acc.blue_first   <= n_base1 + n_bu;
        r_acc.red_second   <= n_base2 + n_rv;
        r_acc.green_second <= n_base2 - n_gu - n_gv;
        r_acc.blue_second  <= n_base2 + n_bu;
    end

    assign o_acc = r_acc;

endmodule

### design/uyvy2rgb_clamp.sv
// Output stage: rounding and clamping of the six channels.
// Depends on uyvy2rgb_pkg.
module uyvy2rgb_clamp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  uyvy2rgb_pkg::t_acc_stage  i_acc,
    output uyvy2rgb_pkg::t_rgb_stage  o_rgb
);

    uyvy2rgb_pkg::t_rgb_stage r_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rgb.valid <= 1'b0;
        end else begin
            r_rgb.valid <= i_acc.valid;
        end
        r_rgb.red_first    <= uyvy2rgb_pkg::clamp_chan(i_acc.red_first);
        r_rgb.green_first  <= uyvy2rgb_pkg::clamp_chan(i_acc.green_first);
        r_rgb.blue_first   <= uyvy2rgb_pkg::clamp_chan(i_acc.blue_first);
        r_rgb.red_second   <= uyvy2rgb_pkg::clamp_chan(i_acc.red_second);
        r_rgb.green_second <= uyvy2rgb_pkg::clamp_chan(i_acc.green_second);
        r_rgb.blue_second  <= uyvy2rgb_pkg::clamp_chan(i_acc.blue_second);
    end

    assign o_rgb = r_rgb;

endmodule

### design/uyvy_to_rgb_pair_converter.sv
// UYVY pair to RGB converter: takes one UYVY group (U, Y0, V, Y1) per clock
// and returns two BT.601 full-range RGB pixels, 8.8 fixed point, clamped to
// 0..65280. Four register stages (chroma offset, multiply, accumulate,
// round/clamp): the result of an accepted item passes through them in that
// order and is shown on the o_ ports with o_valid high for one cycle. One
// item per cycle sustained; busy is high only while in reset. Results
// cannot be held off and must be taken in the cycle they are shown.
// Depends on uyvy2rgb_pkg, uyvy2rgb_mul, uyvy2rgb_acc, uyvy2rgb_clamp.
module uyvy_to_rgb_pair_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_cb_sample,
    input  logic [7:0]  i_luma_first,
    input  logic [7:0]  i_cr_sample,
    input  logic [7:0]  i_luma_second,
    output logic        o_valid,
    output logic [15:0] o_red_first,
    output logic [15:0] o_green_first,
    output logic [15:0] o_blue_first,
    output logic [15:0] o_red_second,
    output logic [15:0] o_green_second,
    output logic [15:0] o_blue_second
);

    logic                      accept;
    uyvy2rgb_pkg::t_prod_stage prod;
    uyvy2rgb_pkg::t_acc_stage  acc;
    uyvy2rgb_pkg::t_rgb_stage  rgb;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    uyvy2rgb_mul u_mul (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (accept),
        .i_cb_sample   (i_cb_sample),
        .i_luma_first  (i_luma_first),
        .i_cr_sample   (i_cr_sample),
        .i_luma_second (i_luma_second),
        .o_prod        (prod)
    );

    uyvy2rgb_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prod  (prod),
        .o_acc   (acc)
    );

    uyvy2rgb_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .o_rgb   (rgb)
    );

    assign o_valid        = rgb.valid;
    assign o_red_first    = rgb.red_first;
    assign o_green_first  = rgb.green_first;
    assign o_blue_first   = rgb.blue_first;
    assign o_red_second   = rgb.red_second;
    assign o_green_second = rgb.green_second;
    assign o_blue_second  = rgb.blue_second;

`ifndef SYNTHESIS
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 4))
        else $error("result without an accepted item");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(accept, 4) && $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1))
        |-> o_valid)
        else $error("accepted item produced no result");

    a_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red_first <= uyvy2rgb_pkg::FULL_SCALE)
                 && (o_green_first <= uyvy2rgb_pkg::FULL_SCALE)
                 && (o_blue_first <= uyvy2rgb_pkg::FULL_SCALE)
                 && (o_red_second <= uyvy2rgb_pkg::FULL_SCALE)
                 && (o_green_second <= uyvy2rgb_pkg::FULL_SCALE)
                 && (o_blue_second <= uyvy2rgb_pkg::FULL_SCALE))
        else $error("channel above full scale");
`endif

endmodule

### dv/uyvy_to_rgb_pair_converter_test.sv
// Self-checking testbench for uyvy_to_rgb_pair_converter: directed UYVY groups from a table,
// then random groups; each channel is checked vs typed rows or a BT.601 fixed-point predictor.
// Depends on uyvy2rgb_pkg and the converter RTL.
module uyvy_to_rgb_pair_converter_test;

    localparam int unsigned RANDOM_GROUPS = 1530;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned PIPE_DRAIN    = 12;

    localparam longint K_RV = 91881;
    localparam longint K_GU = 22554;
    localparam longint K_GV = 46802;
    localparam longint K_BU = 116130;

    typedef struct packed {
        logic [15:0] red_first;
        logic [15:0] green_first;
        logic [15:0] blue_first;
        logic [15:0] red_second;
        logic [15:0] green_second;
        logic [15:0] blue_second;
    } t_rgb_pair;

    typedef struct packed {
        logic [7:0] cb;
        logic [7:0] y0;
        logic [7:0] cr;
        logic [7:0] y1;
        logic       known;
        t_rgb_pair  rgb;
    } t_group_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic [7:0]  i_cb_sample   = '0;
    logic [7:0]  i_luma_first  = '0;
    logic [7:0]  i_cr_sample   = '0;
    logic [7:0]  i_luma_second = '0;
    logic        o_valid;
    logic [15:0] o_red_first;
    logic [15:0] o_green_first;
    logic [15:0] o_blue_first;
    logic [15:0] o_red_second;
    logic [15:0] o_green_second;
    logic [15:0] o_blue_second;

    logic        row_known = 1'b0;
    t_rgb_pair   row_rgb   = '0;

    t_rgb_pair   pending_pixels[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          gaps_on = 1'b1;

    // typed rows: all-zero and all-full groups; everything else uses the predictor
    t_group_row directed [20] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1,
          '{16'd0, 16'd34543, 16'd0, 16'd0, 16'd34543, 16'd0}},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1,
          '{16'd65280, 16'd30737, 16'd65280, 16'd65280, 16'd30737, 16'd65280}},
        '{8'd0,   8'd255, 8'd0,   8'd255, 1'b0, '0},
        '{8'd255, 8'd0,   8'd255, 8'd0,   1'b0, '0},
        '{8'd0,   8'd0,   8'd255, 8'd255, 1'b0, '0},
        '{8'd255, 8'd255, 8'd0,   8'd0,   1'b0, '0},
        '{8'd127, 8'd128, 8'd128, 8'd127, 1'b0, '0},
        '{8'd128, 8'd0,   8'd127, 8'd255, 1'b0, '0},
        '{8'd127, 8'd127, 8'd127, 8'd127, 1'b0, '0},
        '{8'd128, 8'd128, 8'd128, 8'd128, 1'b0, '0},
        '{8'hAA,  8'h55,  8'hAA,  8'h55,  1'b0, '0},
        '{8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0, '0},
        '{8'd1,   8'd254, 8'd254, 8'd1,   1'b0, '0},
        '{8'd254, 8'd1,   8'd1,   8'd254, 1'b0, '0},
        '{8'd0,   8'd1,   8'd0,   8'd1,   1'b0, '0},
        '{8'd255, 8'd254, 8'd0,   8'd16,  1'b0, '0},
        '{8'd0,   8'd235, 8'd255, 8'd16,  1'b0, '0},
        '{8'd255, 8'd16,  8'd0,   8'd235, 1'b0, '0},
        '{8'd128, 8'd255, 8'd128, 8'd0,   1'b0, '0},
        '{8'd127, 8'd0,   8'd127, 8'd255, 1'b0, '0}
    };

    uyvy_to_rgb_pair_converter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cb_sample    (i_cb_sample),
        .i_luma_first   (i_luma_first),
        .i_cr_sample    (i_cr_sample),
        .i_luma_second  (i_luma_second),
        .o_valid        (o_valid),
        .o_red_first    (o_red_first),
        .o_green_first  (o_green_first),
        .o_blue_first   (o_blue_first),
        .o_red_second   (o_red_second),
        .o_green_second (o_green_second),
        .o_blue_second  (o_blue_second)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // 17 fraction bits in, round half up to 8 fraction bits, clamp to 0..full scale
    function automatic logic [15:0] scale_channel(longint acc);
        longint q;
        if (acc <= 0) return 16'd0;
        q = (acc + 256) >>> 9;
        if (q > longint'(uyvy2rgb_pkg::FULL_SCALE)) return uyvy2rgb_pkg::FULL_SCALE;
        return q[15:0];
    endfunction

    function automatic t_rgb_pair convert_group(logic [7:0] cb, logic [7:0] y0,
                                                logic [7:0] cr, logic [7:0] y1);
        longint    du;
        longint    dv;
        longint    l0;
        longint    l1;
        t_rgb_pair px;
        du = 2 * longint'(cb) - 255;
        dv = 2 * longint'(cr) - 255;
        l0 = longint'(y0) <<< 17;
        l1 = longint'(y1) <<< 17;
        px.red_first    = scale_channel(l0 + K_RV * dv);
        px.green_first  = scale_channel(l0 - K_GU * du - K_GV * dv);
        px.blue_first   = scale_channel(l0 + K_BU * du);
        px.red_second   = scale_channel(l1 + K_RV * dv);
        px.green_second = scale_channel(l1 - K_GU * du - K_GV * dv);
        px.blue_second  = scale_channel(l1 + K_BU * du);
        return px;
    endfunction

    task automatic check_channel(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin : score_results
        t_rgb_pair want;
        if (o_valid === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %h", $time,
                         {o_red_first, o_green_first, o_blue_first,
                          o_red_second, o_green_second, o_blue_second});
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                check_channel("red_first",    want.red_first,    o_red_first);
                check_channel("green_first",  want.green_first,  o_green_first);
                check_channel("blue_first",   want.blue_first,   o_blue_first);
                check_channel("red_second",   want.red_second,   o_red_second);
                check_channel("green_second", want.green_second, o_green_second);
                check_channel("blue_second",  want.blue_second,  o_blue_second);
            end
        end
        if (i_rst_n && start && !busy) begin
            if (row_known)
                pending_pixels.push_back(row_rgb);
            else
                pending_pixels.push_back(convert_group(i_cb_sample, i_luma_first,
                                                       i_cr_sample, i_luma_second));
        end
    end

    task automatic send_group(t_group_row r);
        while (gaps_on && $urandom_range(99) < 36) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cb_sample   <= r.cb;
        i_luma_first  <= r.y0;
        i_cr_sample   <= r.cr;
        i_luma_second <= r.y1;
        row_known     <= r.known;
        row_rgb       <= r.rgb;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd127 + 8'($urandom_range(1));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int unsigned n;
        t_group_row  r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_group(directed[k]);
        for (n = 0; n < RANDOM_GROUPS; n++) begin
            gaps_on = !(n >= 500 && n < 800);
            if (n == 1000) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_pixels.size() != 0) @(posedge i_clk);
            end
            r    = '0;
            r.cb = pick_byte();
            r.y0 = pick_byte();
            r.cr = pick_byte();
            r.y1 = pick_byte();
            send_group(r);
        end
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
design/uyvy2rgb_pkg.sv
design/uyvy2rgb_mul.sv
design/uyvy2rgb_acc.sv
design/uyvy2rgb_clamp.sv
design/uyvy_to_rgb_pair_converter.sv
dv/uyvy_to_rgb_pair_converter_test.sv
